FILE: design/fpqs_pkg.sv
package fpqs_pkg;

   // Field widths
   localparam int BYTES_W = 16;
   localparam int SRTT_W  = 32;
   localparam int CNT_W   = 16;
   localparam int SCORE_W = 12;

   // Divider geometry: 20 quotient bits cover every breakpoint, larger values saturate
   localparam int QUO_W     = 20;
   localparam int THR_NUM_W = 47;
   localparam int PCT_NUM_W = 31;
   localparam int MS_W      = 13;
   localparam int X_W       = 21;
   localparam int DIFF_W    = 15;
   localparam int GRADE_W   = 9;
   localparam int SUM_W     = 13;

   // bytes * 2048000000 = (bytes * 125000) << 14
   localparam logic [32:0] THR_MUL   = 33'd125000;
   localparam int          THR_SHIFT = 14;
   // err * 25600 = (err * 100) << 8
   localparam logic [22:0] PCT_MUL   = 23'd100;
   // floor(srtt / 1e6) = (srtt * MS_RECIP) >> MS_SHIFT, exact over 32 bits
   localparam logic [62:0] MS_RECIP  = 63'd1125899907;
   localparam int          MS_SHIFT  = 50;
   // floor(d / 100) = (d * 5243) >> 19 for d below 25600
   localparam logic [27:0] DIV100_MUL = 28'd5243;

   localparam logic [DIFF_W-1:0] FULL_100 = DIFF_W'(100 * 256);
   localparam logic [DIFF_W-1:0] FULL_1   = DIFF_W'(256);
   localparam logic [SUM_W-1:0]  SCORE_BASE = SUM_W'(256 + 1024 + 1024);

   // Breakpoints in Q8
   localparam logic [X_W-1:0] THR_A0 = X_W'(700 * 256);
   localparam logic [X_W-1:0] THR_B0 = X_W'(800 * 256);
   localparam logic [X_W-1:0] THR_A1 = X_W'(1100 * 256);
   localparam logic [X_W-1:0] THR_B1 = X_W'(1200 * 256);
   localparam logic [X_W-1:0] THR_A2 = X_W'(2100 * 256);
   localparam logic [X_W-1:0] THR_B2 = X_W'(2200 * 256);
   localparam logic [X_W-1:0] RTT_A0 = X_W'(300 * 256);
   localparam logic [X_W-1:0] RTT_B0 = X_W'(400 * 256);
   localparam logic [X_W-1:0] RTT_A1 = X_W'(500 * 256);
   localparam logic [X_W-1:0] RTT_B1 = X_W'(600 * 256);
   localparam logic [X_W-1:0] RTT_A2 = X_W'(800 * 256);
   localparam logic [X_W-1:0] RTT_B2 = X_W'(900 * 256);
   localparam logic [X_W-1:0] PCT_A0 = X_W'(5 * 256);
   localparam logic [X_W-1:0] PCT_B0 = X_W'(6 * 256);
   localparam logic [X_W-1:0] PCT_A1 = X_W'(14 * 256);
   localparam logic [X_W-1:0] PCT_B1 = X_W'(15 * 256);
   localparam logic [X_W-1:0] PCT_A2 = X_W'(24 * 256);
   localparam logic [X_W-1:0] PCT_B2 = X_W'(25 * 256);

   // Rising edge before the divide by the edge width: 0, offset above lo, or full
   function automatic logic [DIFF_W-1:0] rise_diff(input logic [X_W-1:0] x,
                                                   input logic [X_W-1:0] lo,
                                                   input logic [X_W-1:0] hi,
                                                   input logic [DIFF_W-1:0] full);
      logic [X_W-1:0] d;
      d = x - lo;
      if (x <= lo) return '0;
      else if (x < hi) return d[DIFF_W-1:0];
      else return full;
   endfunction

   function automatic logic [GRADE_W-1:0] div100(input logic [DIFF_W-1:0] d);
      logic [27:0] p;
      p = 28'(d) * DIV100_MUL;
      return p[27:19];
   endfunction

endpackage

FILE: design/fpqs_req_if.sv
interface fpqs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_bytes;
   logic [31:0] srtt_ns;
   logic [15:0] error_count;
   logic [15:0] probe_count;

   modport source(output valid, payload_bytes, srtt_ns, error_count, probe_count,
                  input ready);
   modport sink(input valid, payload_bytes, srtt_ns, error_count, probe_count,
                output ready);
endinterface

FILE: design/fpqs_rsp_if.sv
interface fpqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] score_q8;

   modport source(output valid, score_q8, input ready);
   modport sink(input valid, score_q8, output ready);
endinterface

FILE: design/fuzzy_path_quality_score_unit.sv
// Fuzzy path quality score unit.
// Requests arrive on req_ch (payload bytes, smoothed RTT in ns, error and
// probe counts); one score per request leaves on rsp_ch as unsigned Q8,
// 768 (3.0) to 3072 (12.0). Both channels move a request when valid and
// ready are high at a rising clock edge.
// Stages: one input stage with the scaling multipliers, 21
// stages of the two restoring dividers (setup plus one quotient bit per
// stage, 20 bits), then edge offsets, divide-by-100, and the output sum.
// Throughput is one request per cycle while rsp_ch is not stalled.
// All stages advance together; when the receiver holds rsp_ch.ready low
// with a result waiting, the whole pipeline holds and req_ch.ready drops.
// Empty slots in the pipeline still move up while the output is free.
// Synchronous reset clears all valid bits; no result is in flight after it.
module fuzzy_path_quality_score_unit (
   input logic        clock,
   input logic        reset,
   fpqs_req_if.sink   req_ch,
   fpqs_rsp_if.source rsp_ch
);
   import fpqs_pkg::*;

   localparam int DIV_LAT = QUO_W + 1;

   logic en;
   logic out_v_ff;

   assign en           = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Input stage: scale numerators, convert RTT to whole ms
   logic                 s1_v_ff;
   logic [THR_NUM_W-1:0] thr_num_ff;
   logic [PCT_NUM_W-1:0] pct_num_ff;
   logic [SRTT_W-1:0]    srtt_ff;
   logic [CNT_W-1:0]     probe_ff;
   logic                 probe_zero_ff;
   logic [MS_W-1:0]      ms_ff;
   logic [32:0]          thr_prod;
   logic [22:0]          pct_prod;
   logic [62:0]          ms_prod;

   assign thr_prod = 33'(req_ch.payload_bytes) * THR_MUL;
   assign pct_prod = 23'(req_ch.error_count) * PCT_MUL;
   assign ms_prod  = 63'(req_ch.srtt_ns) * MS_RECIP;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         thr_num_ff    <= {thr_prod, THR_SHIFT'(0)};
         pct_num_ff    <= {pct_prod, 8'd0};
         srtt_ff       <= req_ch.srtt_ns;
         probe_ff      <= req_ch.probe_count;
         probe_zero_ff <= req_ch.probe_count == '0;
         ms_ff         <= ms_prod[MS_SHIFT +: MS_W];
      end
   end

   // Dividers: saturated quotients stand above every breakpoint
   logic [QUO_W-1:0] thr_q;
   logic [QUO_W-1:0] pct_q;

   fpqs_div #(.NUM_W(THR_NUM_W), .DEN_W(SRTT_W), .QW(QUO_W)) u_thr_div (
      .clock(clock), .en(en), .num(thr_num_ff), .den(srtt_ff), .quo(thr_q)
   );

   fpqs_div #(.NUM_W(PCT_NUM_W), .DEN_W(CNT_W), .QW(QUO_W)) u_pct_div (
      .clock(clock), .en(en), .num(pct_num_ff), .den(probe_ff), .quo(pct_q)
   );

   // Carry valid, ms and the zero-probe flag beside the dividers
   logic            dv_ff [0:DIV_LAT-1];
   logic [MS_W-1:0] dms_ff [0:DIV_LAT-1];
   logic            dpz_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= s1_v_ff;
         for (int k = 1; k < DIV_LAT; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dms_ff[0] <= ms_ff;
         dpz_ff[0] <= probe_zero_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            dms_ff[k] <= dms_ff[k-1];
            dpz_ff[k] <= dpz_ff[k-1];
         end
      end
   end

   // Edge offsets for all nine memberships
   logic              g1_v_ff;
   logic [DIFF_W-1:0] dt_ff [0:2];
   logic [DIFF_W-1:0] dr_ff [0:2];
   logic [DIFF_W-1:0] dp_ff [0:2];
   logic [X_W-1:0]    thr_x;
   logic [X_W-1:0]    rtt_x;
   logic [X_W-1:0]    pct_x;

   assign thr_x = X_W'(thr_q);
   assign rtt_x = {dms_ff[DIV_LAT-1], 8'd0};
   assign pct_x = dpz_ff[DIV_LAT-1] ? '0 : X_W'(pct_q);

   always_ff @(posedge clock) begin
      if (reset) g1_v_ff <= 1'b0;
      else if (en) g1_v_ff <= dv_ff[DIV_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dt_ff[0] <= rise_diff(thr_x, THR_A0, THR_B0, FULL_100);
         dt_ff[1] <= rise_diff(thr_x, THR_A1, THR_B1, FULL_100);
         dt_ff[2] <= rise_diff(thr_x, THR_A2, THR_B2, FULL_100);
         dr_ff[0] <= rise_diff(rtt_x, RTT_A0, RTT_B0, FULL_100);
         dr_ff[1] <= rise_diff(rtt_x, RTT_A1, RTT_B1, FULL_100);
         dr_ff[2] <= rise_diff(rtt_x, RTT_A2, RTT_B2, FULL_100);
         dp_ff[0] <= rise_diff(pct_x, PCT_A0, PCT_B0, FULL_1);
         dp_ff[1] <= rise_diff(pct_x, PCT_A1, PCT_B1, FULL_1);
         dp_ff[2] <= rise_diff(pct_x, PCT_A2, PCT_B2, FULL_1);
      end
   end

   // Scale the 100-wide edges to Q8 grades
   logic               g2_v_ff;
   logic [GRADE_W-1:0] rt_ff [0:2];
   logic [GRADE_W-1:0] rr_ff [0:2];
   logic [GRADE_W-1:0] rp_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) g2_v_ff <= 1'b0;
      else if (en) g2_v_ff <= g1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            rt_ff[k] <= div100(dt_ff[k]);
            rr_ff[k] <= div100(dr_ff[k]);
            rp_ff[k] <= dp_ff[k][GRADE_W-1:0];
         end
      end
   end

   // Sum: throughput grades add, RTT and error grades subtract
   logic [SUM_W-1:0]   score_in;
   logic [SCORE_W-1:0] score_ff;

   assign score_in = SCORE_BASE
                   + SUM_W'(rt_ff[0]) + SUM_W'(rt_ff[1]) + SUM_W'(rt_ff[2])
                   - SUM_W'(rr_ff[0]) - SUM_W'(rr_ff[1]) - SUM_W'(rr_ff[2])
                   - SUM_W'(rp_ff[0]) - SUM_W'(rp_ff[1]) - SUM_W'(rp_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= g2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) score_ff <= score_in[SCORE_W-1:0];
   end

   assign rsp_ch.valid    = out_v_ff;
   assign rsp_ch.score_q8 = score_ff;
endmodule

FILE: design/fpqs_div.sv
module fpqs_div #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 32,
   parameter int QW    = 20
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QW-1:0]    quo
);
   localparam int CW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

   logic [CW-1:0]    rem_ff [0:QW];
   logic [DEN_W-1:0] den_ff [0:QW];
   logic [QW-1:0]    q_ff   [0:QW];
   logic             sat_ff [0:QW];

   // Setup: flag quotients that do not fit in QW bits (zero divisor included)
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= CW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= CW'(num) >= (CW'(den) << QW);
      end
   end

   // One restoring step per stage, most significant quotient bit first
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [CW-1:0] sh;
      assign sh = CW'(den_ff[k-1]) << (QW - k);
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            if (rem_ff[k-1] >= sh) begin
               rem_ff[k] <= rem_ff[k-1] - sh;
               q_ff[k]   <= q_ff[k-1] | (QW'(1) << (QW - k));
            end else begin
               rem_ff[k] <= rem_ff[k-1];
               q_ff[k]   <= q_ff[k-1];
            end
         end
      end
   end

   assign quo = sat_ff[QW] ? '1 : q_ff[QW];
endmodule

FILE: tb/sv/fpqs_tb_if.sv
package fpqs_tb_pkg;
   import fpqs_pkg::*;

   // One path measurement as sent on the request channel
   typedef struct packed {
      logic [BYTES_W-1:0] payload_bytes;
      logic [SRTT_W-1:0]  srtt_ns;
      logic [CNT_W-1:0]   error_count;
      logic [CNT_W-1:0]   probe_count;
   } path_sample_type;
endpackage

FILE: tb/sv/tb.sv
module tb;
   import fpqs_pkg::*;
   import fpqs_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpqs_req_if req_ch();
   fpqs_rsp_if rsp_ch();

   fuzzy_path_quality_score_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   logic [SCORE_W-1:0] score_queue[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #10 clock = ~clock;

   // Rising edge grade in Q8
   function automatic longint unsigned edge_up(longint unsigned x, int a, int b);
      longint unsigned lo, hi;
      lo = longint'(a) * 256;
      hi = longint'(b) * 256;
      if (x <= lo) return 0;
      if (x < hi) return (x - lo) / (b - a);
      return 256;
   endfunction

   function automatic longint unsigned edge_down(longint unsigned x, int c, int d);
      return 256 - edge_up(x, c, d);
   endfunction

   function automatic longint unsigned plateau(longint unsigned x, int a, int b,
                                               int c, int d);
      if (x <= longint'(c) * 256) return edge_up(x, a, b);
      return edge_down(x, c, d);
   endfunction

   // Compute the expected score for one path sample
   function automatic logic [SCORE_W-1:0] quality_score(path_sample_type s);
      longint unsigned thr, rtt, pct, total;
      if (s.srtt_ns == 0) thr = 2200 * 256;
      else thr = longint'(s.payload_bytes) * 64'd2048000000 / longint'(s.srtt_ns);
      rtt = (longint'(s.srtt_ns) / 1000000) * 256;
      if (s.probe_count == 0) pct = 0;
      else begin
         pct = longint'(s.error_count) * 25600 / longint'(s.probe_count);
         if (pct > 255 * 256) pct = 255 * 256;
      end
      total = 4 * edge_up(thr, 2100, 2200) + 3 * plateau(thr, 1100, 1200, 2100, 2200)
            + 2 * plateau(thr, 700, 800, 1100, 1200) + edge_down(thr, 700, 800)
            + 4 * edge_down(rtt, 300, 400) + 3 * plateau(rtt, 300, 400, 500, 600)
            + 2 * plateau(rtt, 500, 600, 800, 900) + edge_up(rtt, 800, 900)
            + 4 * edge_down(pct, 5, 6) + 3 * plateau(pct, 5, 6, 14, 15)
            + 2 * plateau(pct, 14, 15, 24, 25) + edge_up(pct, 24, 25);
      return total[SCORE_W-1:0];
   endfunction

   // Send one request, idling beforehand at the current rate
   task automatic send_sample(path_sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.payload_bytes <= s.payload_bytes;
      req_ch.srtt_ns       <= s.srtt_ns;
      req_ch.error_count   <= s.error_count;
      req_ch.probe_count   <= s.probe_count;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      score_queue.push_back(quality_score(s));
   endtask

   task automatic send_fields(logic [15:0] b, logic [31:0] r, logic [15:0] e,
                              logic [15:0] p);
      path_sample_type s;
      s = '{b, r, e, p};
      send_sample(s);
   endtask

   // Drive receiver ready at the current idle rate
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check each result against the oldest expected score
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (score_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_ch.score_q8);
         end else begin
            logic [SCORE_W-1:0] want;
            want = score_queue.pop_front();
            if (want !== rsp_ch.score_q8) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("score mismatch: expected %0d actual %0d", want,
                           rsp_ch.score_q8);
            end
         end
      end
   end

   // Drop valid and hold until every score is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (score_queue.size() != 0) @(posedge clock);
   endtask

   // Field extremes and special cases
   task automatic test_directed();
      send_fields(16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
      send_fields(16'hFFFF, 32'h0000_0000, 16'hFFFF, 16'h0000);
      send_fields(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001);
      send_fields(16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF);
      send_fields(16'hFFFF, 32'h0000_0001, 16'h0001, 16'hFFFF);
      send_fields(16'd1500, 32'd350_000_000, 16'd5, 16'd100);
      send_fields(16'd1500, 32'd550_000_000, 16'd10, 16'd100);
      send_fields(16'd1500, 32'd850_000_000, 16'd20, 16'd100);
      send_fields(16'd1500, 32'd999_999, 16'd245, 16'd1000);
      send_fields(16'd1024, 32'd4_000_000, 16'd7, 16'd3);
      send_fields(16'd1024, 32'd5_000_000, 16'd55, 16'd1000);
      send_fields(16'd1024, 32'd8_000_000, 16'd145, 16'd1000);
      send_fields(16'd1024, 32'd11_000_000, 16'd3, 16'd1);
      send_fields(16'd100, 32'd1_000_000, 16'd1, 16'd1);
      send_fields(16'h5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
      send_fields(16'hAAAA, 32'h5555_5555, 16'hAAAA, 16'h5555);
   endtask

   // Random samples, mostly near the breakpoints
   task automatic test_random(int count);
      path_sample_type s;
      repeat (count) begin
         s.payload_bytes = $urandom();
         s.srtt_ns = $urandom();
         s.error_count = $urandom();
         s.probe_count = $urandom();
         case ($urandom_range(3))
            0: s.srtt_ns = $urandom_range(1_100_000_000);
            1: s.srtt_ns = (s.payload_bytes * 64'd2048000000) / (256 *
                           $urandom_range(2400, 600)) + $urandom_range(3);
            2: s.probe_count = $urandom_range(2000, 1);
            default: begin
               s.srtt_ns = $urandom_range(1_000_000, 0);
               s.error_count = $urandom_range(300);
            end
         endcase
         if (s.probe_count != 0 && $urandom_range(1))
            s.error_count = s.error_count % (s.probe_count / 3 + 1);
         send_sample(s);
      end
   endtask

   // Send random samples, hold off until every score is back, then send more
   task automatic test_pause();
      test_random(20);
      wait_drained();
      test_random(20);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.payload_bytes <= '0;
      req_ch.srtt_ns <= '0;
      req_ch.error_count <= '0;
      req_ch.probe_count <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 10;
      recv_idle_pct = 58;
      test_directed();
      test_random(150);
      send_idle_pct = 58;
      recv_idle_pct = 10;
      test_pause();
      test_random(130);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(150);
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && score_queue.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
